// File: rtl/core/rse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rse_pkg;

   localparam int unsigned MAX_PARITY   = 30;
   localparam int unsigned RESET_PARITY = 10;
   localparam int unsigned LEN_W        = $clog2(MAX_PARITY + 1);

   localparam logic [8:0] FIELD_POLY = 9'h11D;
   localparam logic [7:0] GF_MSB     = 8'h80;
   localparam logic [7:0] GF_ONE     = 8'h01;

   typedef struct packed {
      logic       clr;
      logic       shift;
      logic       bld;
      logic [7:0] fb;
      logic [7:0] root;
   } cell_ctl_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_parity;
      logic       last_out;
   } beat_type;

   // multiply by alpha
   function automatic logic [7:0] gf_xtime(input logic [7:0] x);
      logic [7:0] sh;
      sh = {x[6:0], 1'b0};
      if ((x & GF_MSB) != 8'h00) begin
         sh = sh ^ FIELD_POLY[7:0];
      end
      return sh;
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x   = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            acc = acc ^ x;
         end
         x = gf_xtime(x);
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/rse_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module rse_cell (
   input  wire logic                  clock,
   input  wire rse_pkg::cell_ctl_type ctl,
   input  wire logic [7:0]            rem_next,
   input  wire logic [7:0]            gen_prev,
   output logic [7:0]                 rem_out,
   output logic [7:0]                 gen_out
);

   logic [7:0] rem_ff, rem_in;
   logic [7:0] gen_ff, gen_in;

   always_comb begin
      rem_in = rem_ff;
      gen_in = gen_ff;
      if (ctl.clr) begin
         rem_in = 8'h00;
         gen_in = 8'h00;
      end else begin
         if (ctl.shift) begin
            rem_in = rem_next ^ rse_pkg::gf_mul(gen_ff, ctl.fb);
         end
         if (ctl.bld) begin
            gen_in = gen_ff ^ rse_pkg::gf_mul(ctl.root, gen_prev);
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      gen_ff <= gen_in;
   end

   assign rem_out = rem_ff;
   assign gen_out = gen_ff;

endmodule

`default_nettype wire

// File: rtl/core/rse_obuf.sv
`timescale 1ns / 1ps
`default_nettype none

module rse_obuf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rse_pkg::beat_type push_beat,
   output logic                   full,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rse_pkg::beat_type      rsp_beat
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   rse_pkg::beat_type out_ff, out_in;
   rse_pkg::beat_type skid_ff, skid_in;
   logic              free;

   always_comb begin
      free          = !out_valid_ff || rsp_ready;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = push;
            skid_in       = push_beat;
         end else begin
            out_valid_in = push;
            out_in       = push_beat;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_beat  = out_ff;

endmodule

`default_nettype wire

// File: rtl/core/gf256_reed_solomon_encoder.sv
// Systematic Reed-Solomon encoder over GF(256), field polynomial 0x11D, generator roots
// alpha^0 .. alpha^(n-1) for n = csr_write_data parity bytes (0 reads as 1, above 30 as 30;
// 10 after reset). Each data beat goes out unchanged and is folded into a row of 30 byte
// cells that form the division register; a data beat with req_last_byte set is followed
// by n parity beats, most significant first, one per cycle while the output buffer is not
// full, during which req_ready is low. After reset and after every length write the cell
// row builds the generator one root per cycle with req_ready low. A two-entry output
// buffer lets the block take a beat while a result waits on rsp_ready.
`timescale 1ns / 1ps
`default_nettype none

module gf256_reed_solomon_encoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_en,
   input  wire logic [4:0] csr_write_data,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_is_parity,
   output logic            rsp_last_out
);

   localparam int unsigned NCELL = rse_pkg::MAX_PARITY;
   localparam int unsigned LW    = rse_pkg::LEN_W;

   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] bld_cnt_ff, bld_cnt_in;
   logic [LW-1:0] par_cnt_ff, par_cnt_in;
   logic [7:0]    root_ff, root_in;
   logic [LW-1:0] csr_len;

   rse_pkg::cell_ctl_type ctl;
   rse_pkg::beat_type     push_beat;
   rse_pkg::beat_type     rsp_beat;
   logic                  push;
   logic                  full;
   logic                  acc;
   logic                  par_go;

   logic [7:0] rem_w [0:NCELL];
   logic [7:0] gen_w [0:NCELL];

   assign rem_w[NCELL] = 8'h00;
   assign gen_w[0]     = rse_pkg::GF_ONE;

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      rse_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .rem_next (rem_w[i+1]),
         .gen_prev (gen_w[i]),
         .rem_out  (rem_w[i]),
         .gen_out  (gen_w[i+1])
      );
   end

   always_comb begin
      if (csr_write_data == '0) begin
         csr_len = LW'(1);
      end else if (csr_write_data > LW'(rse_pkg::MAX_PARITY)) begin
         csr_len = LW'(rse_pkg::MAX_PARITY);
      end else begin
         csr_len = csr_write_data;
      end
   end

   always_comb begin
      req_ready = (bld_cnt_ff == '0) && (par_cnt_ff == '0) && !full;
      acc       = req_valid && req_ready;
      par_go    = (par_cnt_ff != '0) && !full;
      push      = acc || par_go;

      len_in     = len_ff;
      bld_cnt_in = bld_cnt_ff;
      par_cnt_in = par_cnt_ff;
      root_in    = root_ff;

      ctl.clr   = reset || csr_write_en;
      ctl.shift = push;
      ctl.bld   = bld_cnt_ff != '0;
      ctl.fb    = acc ? (req_data_byte ^ rem_w[0]) : 8'h00;
      ctl.root  = root_ff;

      if (acc) begin
         push_beat.out_byte  = req_data_byte;
         push_beat.is_parity = 1'b0;
         push_beat.last_out  = 1'b0;
      end else begin
         push_beat.out_byte  = rem_w[0];
         push_beat.is_parity = 1'b1;
         push_beat.last_out  = par_cnt_ff == LW'(1);
      end

      if (csr_write_en) begin
         len_in     = csr_len;
         bld_cnt_in = csr_len;
         par_cnt_in = '0;
         root_in    = rse_pkg::GF_ONE;
      end else begin
         if (bld_cnt_ff != '0) begin
            bld_cnt_in = bld_cnt_ff - LW'(1);
            root_in    = rse_pkg::gf_xtime(root_ff);
         end
         if (par_go) begin
            par_cnt_in = par_cnt_ff - LW'(1);
         end else if (acc && req_last_byte) begin
            par_cnt_in = len_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= LW'(rse_pkg::RESET_PARITY);
         bld_cnt_ff <= LW'(rse_pkg::RESET_PARITY);
         par_cnt_ff <= '0;
         root_ff    <= rse_pkg::GF_ONE;
      end else begin
         len_ff     <= len_in;
         bld_cnt_ff <= bld_cnt_in;
         par_cnt_ff <= par_cnt_in;
         root_ff    <= root_in;
      end
   end

   rse_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_beat (push_beat),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

   assign rsp_out_byte  = rsp_beat.out_byte;
   assign rsp_is_parity = rsp_beat.is_parity;
   assign rsp_last_out  = rsp_beat.last_out;

   a_par_count: assert property (@(posedge clock) disable iff (reset)
      (acc && req_last_byte && !csr_write_en) |=> (par_cnt_ff == $past(len_ff)))
      else $error("parity count does not match length after last beat");

   a_rem_drained: assert property (@(posedge clock) disable iff (reset)
      (par_go && (par_cnt_ff == LW'(1))) |=> (rem_w[0] == 8'h00))
      else $error("remainder not cleared after final parity beat");

   a_gen_top: assert property (@(posedge clock) disable iff (reset)
      (bld_cnt_ff == '0) |-> (gen_w[len_ff] != 8'h00))
      else $error("generator constant coefficient is zero");

endmodule

`default_nettype wire
